/* rtl/tmpg_pkg.sv */
package tmpg_pkg;

   localparam int DEF_MAX_SPLITS    = 128;
   localparam int DEF_CORDIC_STAGES = 16;

   localparam int DIV_BITS   = 32;
   localparam int DIV_W      = 9;
   localparam int POS_W      = 7;
   localparam int SPLITS_W   = 8;
   localparam int RADIUS_W   = 16;
   localparam int IDX_W      = 14;
   localparam int COORD_W    = 18;
   localparam int TRIG_W     = 18;
   localparam int UV_W       = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

   localparam logic [RADIUS_W-1:0] INNER_RESET = 16'd2048;
   localparam logic [RADIUS_W-1:0] OUTER_RESET = 16'd4096;
   localparam logic [SPLITS_W-1:0] RING_RESET  = 8'd8;
   localparam logic [SPLITS_W-1:0] TUBE_RESET  = 8'd5;

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quad_type;

   typedef enum logic [2:0] {
      REG_INNER_RADIUS = 3'd0,
      REG_OUTER_RADIUS = 3'd1,
      REG_RING_SPLITS  = 3'd2,
      REG_TUBE_SPLITS  = 3'd3,
      REG_UV_ENABLE    = 3'd4
   } csr_reg_type;

   function automatic logic [31:0] atan_q30(input int unsigned stage);
      logic [31:0] val;
      case (stage)
         0:  val = 32'h3243F6A8;
         1:  val = 32'h1DAC6705;
         2:  val = 32'h0FADBAFC;
         3:  val = 32'h07F56EA6;
         4:  val = 32'h03FEAB76;
         5:  val = 32'h01FFD55B;
         6:  val = 32'h00FFFAAA;
         7:  val = 32'h007FFF55;
         8:  val = 32'h003FFFEA;
         9:  val = 32'h001FFFFD;
         10: val = 32'h000FFFFF;
         11: val = 32'h0007FFFF;
         12: val = 32'h0003FFFF;
         13: val = 32'h0001FFFF;
         14: val = 32'h0000FFFF;
         15: val = 32'h00007FFF;
         16: val = 32'h00003FFF;
         17: val = 32'h00001FFF;
         18: val = 32'h00000FFF;
         19: val = 32'h000007FF;
         20: val = 32'h000003FF;
         21: val = 32'h000001FF;
         22: val = 32'h000000FF;
         23: val = 32'h0000007F;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

/* rtl/torus_mesh_point_generator_top.sv */
// Torus mesh point generator.
// Input channel req_*: one mesh point (ring index, tube index) per transfer.
// Result channel rsp_*: vertex index, vertex position, quad corners and uv.
// Points with an index at or beyond the split counts, or with outer radius below
// inner radius, or with split counts above MAX_SPLITS, give no result.
// Registers sit on an APB-style port csr_* at byte addresses 0,4,8,12,16;
// write them only while no point is in flight.
// The 32-step restoring divider pipeline, the CORDIC stages and the
// five-stage coordinate multiply and round section make up the pipeline.
// Throughput: one point per cycle while the receiver does not stall.
// Reset clears the pipeline valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
module torus_mesh_point_generator_top #(
   parameter int MAX_SPLITS    = tmpg_pkg::DEF_MAX_SPLITS,
   parameter int CORDIC_STAGES = tmpg_pkg::DEF_CORDIC_STAGES
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tmpg_pkg::POS_W-1:0]            req_ring_index,
   input  logic [tmpg_pkg::POS_W-1:0]            req_tube_index,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tmpg_pkg::IDX_W-1:0]            rsp_vertex_index,
   output logic signed [tmpg_pkg::COORD_W-1:0]   rsp_x_coord,
   output logic signed [tmpg_pkg::COORD_W-1:0]   rsp_y_coord,
   output logic signed [tmpg_pkg::COORD_W-1:0]   rsp_z_coord,
   output logic [tmpg_pkg::IDX_W-1:0]            rsp_corner_a,
   output logic [tmpg_pkg::IDX_W-1:0]            rsp_corner_b,
   output logic [tmpg_pkg::IDX_W-1:0]            rsp_corner_c,
   output logic [tmpg_pkg::IDX_W-1:0]            rsp_corner_d,
   output logic [tmpg_pkg::UV_W-1:0]             rsp_u_low,
   output logic [tmpg_pkg::UV_W-1:0]             rsp_u_high,
   output logic [tmpg_pkg::UV_W-1:0]             rsp_v_low,
   output logic [tmpg_pkg::UV_W-1:0]             rsp_v_high,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tmpg_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tmpg_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tmpg_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int DB     = tmpg_pkg::DIV_BITS;
   localparam int DW     = tmpg_pkg::DIV_W;
   localparam int PW     = tmpg_pkg::POS_W;
   localparam int SW     = tmpg_pkg::SPLITS_W;
   localparam int RW     = tmpg_pkg::RADIUS_W;
   localparam int IW     = tmpg_pkg::IDX_W;
   localparam int UW     = tmpg_pkg::UV_W;
   localparam int TW     = tmpg_pkg::TRIG_W;
   localparam int LAT    = DB + CORDIC_STAGES + 7;
   localparam int MW     = PW + SW;

   // configuration registers
   logic [RW-1:0] inner_ff;
   logic [RW-1:0] outer_ff;
   logic [SW-1:0] ring_splits_ff;
   logic [SW-1:0] tube_splits_ff;
   logic          uv_enable_ff;
   logic          csr_write;
   tmpg_pkg::csr_reg_type csr_sel;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = tmpg_pkg::csr_reg_type'(csr_paddr[tmpg_pkg::CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff       <= tmpg_pkg::INNER_RESET;
         outer_ff       <= tmpg_pkg::OUTER_RESET;
         ring_splits_ff <= tmpg_pkg::RING_RESET;
         tube_splits_ff <= tmpg_pkg::TUBE_RESET;
         uv_enable_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_sel)
            tmpg_pkg::REG_INNER_RADIUS: inner_ff       <= csr_pwdata[RW-1:0];
            tmpg_pkg::REG_OUTER_RADIUS: outer_ff       <= csr_pwdata[RW-1:0];
            tmpg_pkg::REG_RING_SPLITS:  ring_splits_ff <= csr_pwdata[SW-1:0];
            tmpg_pkg::REG_TUBE_SPLITS:  tube_splits_ff <= csr_pwdata[SW-1:0];
            tmpg_pkg::REG_UV_ENABLE:    uv_enable_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         tmpg_pkg::REG_INNER_RADIUS: csr_prdata = tmpg_pkg::CSR_DATA_W'(inner_ff);
         tmpg_pkg::REG_OUTER_RADIUS: csr_prdata = tmpg_pkg::CSR_DATA_W'(outer_ff);
         tmpg_pkg::REG_RING_SPLITS:  csr_prdata = tmpg_pkg::CSR_DATA_W'(ring_splits_ff);
         tmpg_pkg::REG_TUBE_SPLITS:  csr_prdata = tmpg_pkg::CSR_DATA_W'(tube_splits_ff);
         tmpg_pkg::REG_UV_ENABLE:    csr_prdata = tmpg_pkg::CSR_DATA_W'(uv_enable_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic           advance;
   logic           keep;
   logic [LAT:0]   valid_ff;
   logic [LAT:0]   valid_in;

   assign advance   = !valid_ff[LAT] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT];

   assign keep = (outer_ff >= inner_ff)
              && (32'(ring_splits_ff) <= MAX_SPLITS)
              && (32'(tube_splits_ff) <= MAX_SPLITS)
              && ({1'b0, req_ring_index} < ring_splits_ff)
              && ({1'b0, req_tube_index} < tube_splits_ff);

   assign valid_in = {valid_ff[LAT-1:0], req_valid && keep};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // capture stage
   logic [PW-1:0] ring_ff;
   logic [PW-1:0] tube_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ring_ff <= req_ring_index;
         tube_ff <= req_tube_index;
      end
   end

   // index path
   logic [SW-1:0] ring_next;
   logic [SW-1:0] tube_next;
   logic          tube_last;
   logic [MW-1:0] ring_base_ff;
   logic [MW-1:0] next_base_ff;
   logic [PW-1:0] tube1_ff;
   logic          last1_ff;
   logic [IW-1:0] vtx;
   logic [IW-1:0] vtx_up;
   logic [IW-1:0] nxt;
   logic [IW-1:0] nxt_up;
   logic [IW-1:0] corner_a;
   logic [IW-1:0] corner_b;
   logic [IW-1:0] corner_c;
   logic [IW-1:0] corner_d;

   assign ring_next = ((SW'(ring_ff) + 1'b1) == ring_splits_ff) ? '0 : SW'(ring_ff) + 1'b1;
   assign tube_last = ((SW'(tube_ff) + 1'b1) == tube_splits_ff);
   assign tube_next = tube_last ? '0 : SW'(tube_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (advance) begin
         ring_base_ff <= MW'(ring_ff) * MW'(tube_splits_ff);
         next_base_ff <= MW'(ring_next) * MW'(tube_splits_ff);
         tube1_ff     <= tube_ff;
         last1_ff     <= tube_last;
      end
   end

   assign vtx    = IW'(ring_base_ff + MW'(tube1_ff));
   assign vtx_up = IW'(ring_base_ff + MW'(tube1_ff) + 1'b1);
   assign nxt    = IW'(next_base_ff + MW'(tube1_ff));
   assign nxt_up = IW'(next_base_ff + MW'(tube1_ff) + 1'b1);

   assign corner_a = last1_ff ? IW'(ring_base_ff) : vtx;
   assign corner_b = last1_ff ? IW'(next_base_ff) : vtx_up;
   assign corner_c = last1_ff ? nxt : nxt_up;
   assign corner_d = last1_ff ? vtx : nxt;

   tmpg_delay #(
      .WIDTH (5 * IW),
      .DEPTH (LAT - 1)
   ) u_index_delay (
      .clock  (clock),
      .enable (advance),
      .din    ({vtx, corner_a, corner_b, corner_c, corner_d}),
      .dout   ({rsp_vertex_index, rsp_corner_a, rsp_corner_b, rsp_corner_c,
                rsp_corner_d})
   );

   // dividers: turn phases and uv fractions
   logic [DW-1:0] ring_div;
   logic [DW-1:0] tube_div;
   logic [DW-1:0] ring_div1;
   logic [DW-1:0] tube_div1;
   logic [DB-1:0] phase_ring;
   logic [DB-1:0] phase_tube;
   logic [DB-1:0] q_u_low;
   logic [DB-1:0] q_u_high;
   logic [DB-1:0] q_v_low;
   logic [DB-1:0] q_v_high;

   assign ring_div  = DW'(ring_splits_ff);
   assign tube_div  = DW'(tube_splits_ff);
   assign ring_div1 = DW'(ring_splits_ff) + 1'b1;
   assign tube_div1 = DW'(tube_splits_ff) + 1'b1;

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_ring (
      .clock (clock), .enable (advance),
      .dividend (DW'(ring_ff)), .divisor (ring_div), .quotient (phase_ring)
   );

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_tube (
      .clock (clock), .enable (advance),
      .dividend (DW'(tube_ff)), .divisor (tube_div), .quotient (phase_tube)
   );

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_u_low (
      .clock (clock), .enable (advance),
      .dividend (DW'(ring_ff)), .divisor (ring_div1), .quotient (q_u_low)
   );

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_u_high (
      .clock (clock), .enable (advance),
      .dividend (DW'(ring_ff) + 1'b1), .divisor (ring_div1), .quotient (q_u_high)
   );

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_v_low (
      .clock (clock), .enable (advance),
      .dividend (DW'(tube_ff)), .divisor (tube_div1), .quotient (q_v_low)
   );

   tmpg_divider #(.DW(DW), .QW(DB)) u_div_v_high (
      .clock (clock), .enable (advance),
      .dividend (DW'(tube_next)), .divisor (tube_div1), .quotient (q_v_high)
   );

   logic [4*UW-1:0] uv_bundle;

   assign uv_bundle = uv_enable_ff
      ? {q_u_low[DB-1 -: UW], q_u_high[DB-1 -: UW], q_v_low[DB-1 -: UW],
         q_v_high[DB-1 -: UW]}
      : '0;

   tmpg_delay #(
      .WIDTH (4 * UW),
      .DEPTH (LAT - DB)
   ) u_uv_delay (
      .clock  (clock),
      .enable (advance),
      .din    (uv_bundle),
      .dout   ({rsp_u_low, rsp_u_high, rsp_v_low, rsp_v_high})
   );

   // trigonometry and coordinates
   logic signed [TW-1:0] cos_ring;
   logic signed [TW-1:0] sin_ring;
   logic signed [TW-1:0] cos_tube;
   logic signed [TW-1:0] sin_tube;

   tmpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ring (
      .clock (clock), .enable (advance), .phase (phase_ring),
      .cos_out (cos_ring), .sin_out (sin_ring)
   );

   tmpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_tube (
      .clock (clock), .enable (advance), .phase (phase_tube),
      .cos_out (cos_tube), .sin_out (sin_tube)
   );

   tmpg_coord u_coord (
      .clock       (clock),
      .enable      (advance),
      .sum_radius  ((RW+1)'(outer_ff) + (RW+1)'(inner_ff)),
      .diff_radius (outer_ff - inner_ff),
      .cos_ring    (cos_ring),
      .sin_ring    (sin_ring),
      .cos_tube    (cos_tube),
      .sin_tube    (sin_tube),
      .x_coord     (rsp_x_coord),
      .y_coord     (rsp_y_coord),
      .z_coord     (rsp_z_coord)
   );

endmodule

/* rtl/tmpg_divider.sv */
module tmpg_divider #(
   parameter int DW = tmpg_pkg::DIV_W,
   parameter int QW = tmpg_pkg::DIV_BITS
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quotient
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] rem_in [QW];
   logic [QW-1:0] quo_in [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW:0]   rem_dbl;
      logic [QW-1:0] quo_prev;
      logic          fits;

      if (k == 0) begin : g_first
         assign rem_dbl  = {dividend, 1'b0};
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_dbl  = {rem_ff[k-1], 1'b0};
         assign quo_prev = quo_ff[k-1];
      end

      assign fits      = (rem_dbl >= {1'b0, divisor});
      assign rem_in[k] = fits ? DW'(rem_dbl - {1'b0, divisor}) : rem_dbl[DW-1:0];
      assign quo_in[k] = {quo_prev[QW-2:0], fits};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

/* rtl/tmpg_cordic.sv */
module tmpg_cordic #(
   parameter int STAGES = tmpg_pkg::DEF_CORDIC_STAGES
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [31:0]                         phase,
   output logic signed [tmpg_pkg::TRIG_W-1:0]  cos_out,
   output logic signed [tmpg_pkg::TRIG_W-1:0]  sin_out
);

   localparam int XW = 34;
   localparam int ZW = 33;
   localparam int TW = tmpg_pkg::TRIG_W;
   localparam logic signed [XW-1:0] ROUND_HALF = XW'(8192);

   logic [60:0]              zprod;
   logic signed [ZW-1:0]     z_start;
   logic signed [XW-1:0]     x_ff [STAGES+1];
   logic signed [XW-1:0]     y_ff [STAGES+1];
   logic signed [ZW-1:0]     z_ff [STAGES+1];
   tmpg_pkg::quad_type       quad_ff [STAGES+1];

   logic signed [XW-1:0]     c_full;
   logic signed [XW-1:0]     s_full;
   logic signed [TW-1:0]     c_val;
   logic signed [TW-1:0]     s_val;
   logic signed [TW-1:0]     cos_in;
   logic signed [TW-1:0]     sin_in;
   logic signed [TW-1:0]     cos_ff;
   logic signed [TW-1:0]     sin_ff;

   assign zprod   = 61'(phase[29:0]) * 61'(tmpg_pkg::HALF_PI_Q30);
   assign z_start = $signed({2'b00, zprod[60:30]});

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= XW'(tmpg_pkg::CORDIC_GAIN_Q30);
         y_ff[0]    <= '0;
         z_ff[0]    <= z_start;
         quad_ff[0] <= tmpg_pkg::quad_type'(phase[31:30]);
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_iter
      logic signed [XW-1:0] x_shift;
      logic signed [XW-1:0] y_shift;
      logic signed [ZW-1:0] atan_val;
      logic                 rot_pos;

      assign x_shift  = x_ff[k] >>> k;
      assign y_shift  = y_ff[k] >>> k;
      assign atan_val = ZW'(tmpg_pkg::atan_q30(k));
      assign rot_pos  = ~z_ff[k][ZW-1];

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k+1]    <= rot_pos ? x_ff[k] - y_shift : x_ff[k] + y_shift;
            y_ff[k+1]    <= rot_pos ? y_ff[k] + x_shift : y_ff[k] - x_shift;
            z_ff[k+1]    <= rot_pos ? z_ff[k] - atan_val : z_ff[k] + atan_val;
            quad_ff[k+1] <= quad_ff[k];
         end
      end
   end

   assign c_full = (x_ff[STAGES] + ROUND_HALF) >>> 14;
   assign s_full = (y_ff[STAGES] + ROUND_HALF) >>> 14;
   assign c_val  = c_full[TW-1:0];
   assign s_val  = s_full[TW-1:0];

   always_comb begin
      case (quad_ff[STAGES])
         tmpg_pkg::QUAD_FIRST: begin
            cos_in = c_val;
            sin_in = s_val;
         end
         tmpg_pkg::QUAD_SECOND: begin
            cos_in = -s_val;
            sin_in = c_val;
         end
         tmpg_pkg::QUAD_THIRD: begin
            cos_in = -c_val;
            sin_in = -s_val;
         end
         default: begin
            cos_in = s_val;
            sin_in = -c_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

/* rtl/tmpg_coord.sv */
module tmpg_coord (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic [tmpg_pkg::RADIUS_W:0]           sum_radius,
   input  logic [tmpg_pkg::RADIUS_W-1:0]         diff_radius,
   input  logic signed [tmpg_pkg::TRIG_W-1:0]    cos_ring,
   input  logic signed [tmpg_pkg::TRIG_W-1:0]    sin_ring,
   input  logic signed [tmpg_pkg::TRIG_W-1:0]    cos_tube,
   input  logic signed [tmpg_pkg::TRIG_W-1:0]    sin_tube,
   output logic signed [tmpg_pkg::COORD_W-1:0]   x_coord,
   output logic signed [tmpg_pkg::COORD_W-1:0]   y_coord,
   output logic signed [tmpg_pkg::COORD_W-1:0]   z_coord
);

   localparam int TW = tmpg_pkg::TRIG_W;
   localparam int CW = tmpg_pkg::COORD_W;
   localparam int DW = 35;
   localparam int XW = 36;
   localparam int PW = 38;
   localparam int FW = 56;
   localparam logic signed [FW-1:0] CMAX   = FW'((1 << (CW - 1)) - 1);
   localparam logic signed [FW-1:0] CMIN   = ~CMAX;
   localparam logic signed [FW-1:0] RND_33 = FW'(64'h1_0000_0000);
   localparam logic signed [FW-1:0] RND_17 = FW'(64'h1_0000);

   function automatic logic signed [CW-1:0] clamp(input logic signed [FW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > CMAX) begin
         r = CMAX[CW-1:0];
      end else if (v < CMIN) begin
         r = CMIN[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   logic signed [DW-1:0]   dc_ff;
   logic signed [DW-1:0]   ds1_ff;
   logic signed [TW-1:0]   ci1_ff;
   logic signed [TW:0]     nsi1_ff;

   logic signed [XW-1:0]   x0_ff;
   logic signed [DW-1:0]   ds2_ff;
   logic signed [TW-1:0]   ci2_ff;
   logic signed [TW:0]     nsi2_ff;

   logic signed [18:0]     x0_hi;
   logic signed [18:0]     x0_lo;
   logic signed [PW-1:0]   pxh_ff;
   logic signed [PW-1:0]   pxl_ff;
   logic signed [PW-1:0]   pzh_ff;
   logic signed [PW-1:0]   pzl_ff;
   logic signed [DW-1:0]   ds3_ff;

   logic signed [FW-1:0]   fx_ff;
   logic signed [FW-1:0]   fz_ff;
   logic signed [DW-1:0]   ds4_ff;

   logic signed [FW-1:0]   xr;
   logic signed [FW-1:0]   yr;
   logic signed [FW-1:0]   zr;
   logic signed [CW-1:0]   x_ff;
   logic signed [CW-1:0]   y_ff;
   logic signed [CW-1:0]   z_ff;

   assign x0_hi = x0_ff[XW-1:17];
   assign x0_lo = $signed({2'b00, x0_ff[16:0]});

   assign xr = (fx_ff + RND_33) >>> 33;
   assign zr = (fz_ff + RND_33) >>> 33;
   assign yr = (FW'(ds4_ff) + RND_17) >>> 17;

   always_ff @(posedge clock) begin
      if (enable) begin
         dc_ff   <= $signed({1'b0, diff_radius}) * cos_tube;
         ds1_ff  <= $signed({1'b0, diff_radius}) * sin_tube;
         ci1_ff  <= cos_ring;
         nsi1_ff <= -(TW+1)'(sin_ring);

         x0_ff   <= $signed({3'b000, sum_radius, 16'h0000}) + XW'(dc_ff);
         ds2_ff  <= ds1_ff;
         ci2_ff  <= ci1_ff;
         nsi2_ff <= nsi1_ff;

         pxh_ff  <= ci2_ff * x0_hi;
         pxl_ff  <= ci2_ff * x0_lo;
         pzh_ff  <= nsi2_ff * x0_hi;
         pzl_ff  <= nsi2_ff * x0_lo;
         ds3_ff  <= ds2_ff;

         fx_ff   <= (FW'(pxh_ff) <<< 17) + FW'(pxl_ff);
         fz_ff   <= (FW'(pzh_ff) <<< 17) + FW'(pzl_ff);
         ds4_ff  <= ds3_ff;

         x_ff    <= clamp(xr);
         y_ff    <= clamp(yr);
         z_ff    <= clamp(zr);
      end
   end

   assign x_coord = x_ff;
   assign y_coord = y_ff;
   assign z_coord = z_ff;

endmodule

/* rtl/tmpg_delay.sv */
module tmpg_delay #(
   parameter int WIDTH = tmpg_pkg::IDX_W,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         line_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

/* rtl/tmpg_checker.sv */
module tmpg_assertions (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [tmpg_pkg::IDX_W-1:0]          rsp_vertex_index,
   input logic [tmpg_pkg::IDX_W-1:0]          rsp_corner_a,
   input logic [tmpg_pkg::IDX_W-1:0]          rsp_corner_d,
   input logic signed [tmpg_pkg::COORD_W-1:0] rsp_x_coord
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input blocked without a stalled result");

   a_corner_holds_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_corner_a == rsp_vertex_index || rsp_corner_d == rsp_vertex_index))
      else $error("quad corners do not include the vertex");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_vertex_index)
                                     && $stable(rsp_x_coord)))
      else $error("stalled result changed");

endmodule

bind torus_mesh_point_generator_top tmpg_assertions u_tmpg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_vertex_index (rsp_vertex_index),
   .rsp_corner_a     (rsp_corner_a),
   .rsp_corner_d     (rsp_corner_d),
   .rsp_x_coord      (rsp_x_coord)
);
